// File: hw/rtl/vlps_pkg.sv
// Shared constants, codes and types of the variable-length packet stack.
package vlps_pkg;

  localparam int ENTRY_SLOTS  = 256;
  localparam int BUFFER_BYTES = 4096;
  localparam int MAX_PACKET   = 64;

  localparam int ENTRY_AW = $clog2(ENTRY_SLOTS);
  localparam int CNT_W    = $clog2(ENTRY_SLOTS + 1);
  localparam int BYTE_AW  = $clog2(BUFFER_BYTES);
  localparam int FILL_W   = $clog2(BUFFER_BYTES + 1);
  localparam int LEN_W    = 7;
  localparam int SES_W    = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_BYTE   = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ENTRIES_FULL = 3'd1,
    ST_BUFFER_FULL  = 3'd2,
    ST_TOO_LONG     = 3'd3,
    ST_EMPTY        = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_AW-1:0] offset;
    logic [LEN_W-1:0]   length;
    logic [SES_W-1:0]   session;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic    is_pop;
    status_t status;
    entry_t  ent;
  } job_t;

  typedef struct packed {
    logic               we;
    logic [BYTE_AW-1:0] addr;
    logic [7:0]         data;
  } byte_wr_t;

  typedef struct packed {
    logic pop_done;
  } back_stat_t;

endpackage

// File: hw/rtl/vlps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vlps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/vlps_queue.sv
// Short job queue between the request front end and the result back end.
module vlps_queue import vlps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic enq,
  input  job_t enq_job,
  input  logic deq,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    wptr_nxt  = enq ? ptr_inc(wptr_r) : wptr_r;
    rptr_nxt  = deq ? ptr_inc(rptr_r) : rptr_r;
    count_nxt = count_r;
    if (enq && !deq) begin
      count_nxt = count_r + 1'b1;
    end else if (deq && !enq) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem_r[wptr_r] <= enq_job;
    end
  end

  assign head  = mem_r[rptr_r];
  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

endmodule

// File: hw/rtl/vlps_front.sv
// Front end: takes requests, builds packets, keeps the entry table and queues result jobs.
module vlps_front import vlps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             cmd,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic [SES_W-1:0] session_tag,
  output logic             busy,
  output logic             enq,
  output job_t             enq_job,
  input  logic             q_full,
  input  back_stat_t       back_stat,
  output byte_wr_t         byte_wr
);

  typedef enum logic {
    F_IDLE,
    F_READ
  } fstate_t;

  fstate_t           state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0]  olen_r, olen_nxt;
  logic [SES_W-1:0]  oses_r, oses_nxt;
  status_t           oerr_r, oerr_nxt;
  logic              pop_out_r, pop_out_nxt;

  logic              accept;
  logic [FILL_W:0]   pos;
  logic [SES_W-1:0]  ses_eff;
  status_t           cls_status;
  logic [LEN_W-1:0]  rd_len;
  logic [CNT_W-1:0]  cnt_m1;
  logic              ent_we;
  entry_t            ent_wdata;
  entry_t            ent_rdata;
  logic [ENTRY_W-1:0] ent_rdata_raw;

  assign busy   = q_full || (state_r == F_READ) || pop_out_r;
  assign accept = start && !busy;
  assign cnt_m1 = count_r - 1'b1;
  assign ent_rdata = entry_t'(ent_rdata_raw);

  vlps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRY_SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (count_r[ENTRY_AW-1:0]),
    .wdata (ent_wdata),
    .raddr (cnt_m1[ENTRY_AW-1:0]),
    .rdata (ent_rdata_raw)
  );

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    fill_nxt    = fill_r;
    olen_nxt    = olen_r;
    oses_nxt    = oses_r;
    oerr_nxt    = oerr_r;
    pop_out_nxt = pop_out_r;
    enq         = 1'b0;
    enq_job     = '0;
    byte_wr     = '0;
    ent_we      = 1'b0;
    ent_wdata   = '0;
    ses_eff     = oses_r;
    cls_status  = ST_OK;
    pos         = (FILL_W+1)'(fill_r) + (FILL_W+1)'(olen_r);
    rd_len      = ent_rdata.length;

    if (back_stat.pop_done) begin
      pop_out_nxt = 1'b0;
    end

    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (cmd == CMD_PUSH) begin
            if (olen_r == '0 && oerr_r == ST_OK) begin
              ses_eff = session_tag;
            end
            oses_nxt = ses_eff;
            if (olen_r >= LEN_W'(MAX_PACKET)) begin
              if (oerr_r == ST_OK) begin
                oerr_nxt = ST_TOO_LONG;
              end
            end else begin
              if (pos >= (FILL_W+1)'(BUFFER_BYTES)) begin
                if (oerr_r == ST_OK) begin
                  oerr_nxt = ST_BUFFER_FULL;
                end
              end else if (oerr_r == ST_OK) begin
                byte_wr.we   = 1'b1;
                byte_wr.addr = pos[BYTE_AW-1:0];
                byte_wr.data = data_byte;
              end
              olen_nxt = olen_r + 1'b1;
            end
            if (last_byte) begin
              cls_status = (count_r >= CNT_W'(ENTRY_SLOTS)) ? ST_ENTRIES_FULL : oerr_nxt;
              if (cls_status == ST_OK) begin
                ent_we            = 1'b1;
                ent_wdata.offset  = fill_r[BYTE_AW-1:0];
                ent_wdata.length  = olen_nxt;
                ent_wdata.session = ses_eff;
                count_nxt         = count_r + 1'b1;
                fill_nxt          = fill_r + FILL_W'(olen_nxt);
              end
              enq                 = 1'b1;
              enq_job.status      = cls_status;
              enq_job.ent.session = ses_eff;
              enq_job.ent.length  = olen_nxt;
              olen_nxt            = '0;
              oses_nxt            = '0;
              oerr_nxt            = ST_OK;
            end
          end else begin
            olen_nxt = '0;
            oses_nxt = '0;
            oerr_nxt = ST_OK;
            if (count_r == '0) begin
              enq            = 1'b1;
              enq_job.status = ST_EMPTY;
            end else begin
              state_nxt = F_READ;
            end
          end
        end
      end
      F_READ: begin
        if (rd_len > LEN_W'(MAX_PACKET)) begin
          rd_len = LEN_W'(MAX_PACKET);
        end
        enq = 1'b1;
        if (rd_len == '0) begin
          enq_job.status = ST_EMPTY;
        end else begin
          enq_job.is_pop     = 1'b1;
          enq_job.status     = ST_OK;
          enq_job.ent        = ent_rdata;
          enq_job.ent.length = rd_len;
          count_nxt          = cnt_m1;
          fill_nxt           = (fill_r >= FILL_W'(rd_len)) ? fill_r - FILL_W'(rd_len) : '0;
          pop_out_nxt        = 1'b1;
        end
        state_nxt = F_IDLE;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      count_r   <= '0;
      fill_r    <= '0;
      olen_r    <= '0;
      oses_r    <= '0;
      oerr_r    <= ST_OK;
      pop_out_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      fill_r    <= fill_nxt;
      olen_r    <= olen_nxt;
      oses_r    <= oses_nxt;
      oerr_r    <= oerr_nxt;
      pop_out_r <= pop_out_nxt;
    end
  end

endmodule

// File: hw/rtl/vlps_back.sv
// Back end: drains queued jobs, streams popped bytes from the byte store and drives results.
module vlps_back import vlps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  job_t               q_head,
  output logic               deq,
  output logic [BYTE_AW-1:0] rd_addr,
  input  logic [7:0]         rd_data,
  output back_stat_t         back_stat,
  output logic               out_valid,
  output logic               out_kind,
  output logic [2:0]         out_status,
  output logic [7:0]         out_byte,
  output logic [SES_W-1:0]   out_session,
  output logic [LEN_W-1:0]   out_packet_length,
  output logic               out_final_res
);

  typedef enum logic {
    B_IDLE,
    B_STREAM
  } bstate_t;

  bstate_t            state_r, state_nxt;
  logic [LEN_W-1:0]   idx_r, idx_nxt;
  logic [BYTE_AW-1:0] cur_off_r, cur_off_nxt;
  logic [LEN_W-1:0]   cur_len_r, cur_len_nxt;
  logic [SES_W-1:0]   cur_ses_r, cur_ses_nxt;

  logic               s1_valid_r, s1_valid_nxt;
  kind_t              s1_kind_r, s1_kind_nxt;
  status_t            s1_status_r, s1_status_nxt;
  logic [SES_W-1:0]   s1_ses_r, s1_ses_nxt;
  logic [LEN_W-1:0]   s1_len_r, s1_len_nxt;
  logic               s1_final_r, s1_final_nxt;

  logic               out_valid_r;
  kind_t              out_kind_r;
  status_t            out_status_r;
  logic [7:0]         out_byte_r;
  logic [SES_W-1:0]   out_ses_r;
  logic [LEN_W-1:0]   out_len_r;
  logic               out_final_r;

  always_comb begin
    state_nxt          = state_r;
    idx_nxt            = idx_r;
    cur_off_nxt        = cur_off_r;
    cur_len_nxt        = cur_len_r;
    cur_ses_nxt        = cur_ses_r;
    s1_valid_nxt       = 1'b0;
    s1_kind_nxt        = KIND_STATUS;
    s1_status_nxt      = ST_OK;
    s1_ses_nxt         = cur_ses_r;
    s1_len_nxt         = cur_len_r;
    s1_final_nxt       = 1'b0;
    deq                = 1'b0;
    back_stat.pop_done = 1'b0;
    rd_addr            = cur_off_r + BYTE_AW'(idx_r);

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          deq          = 1'b1;
          s1_valid_nxt = 1'b1;
          s1_ses_nxt   = q_head.ent.session;
          s1_len_nxt   = q_head.ent.length;
          if (q_head.is_pop) begin
            rd_addr     = q_head.ent.offset;
            s1_kind_nxt = KIND_BYTE;
            cur_off_nxt = q_head.ent.offset;
            cur_len_nxt = q_head.ent.length;
            cur_ses_nxt = q_head.ent.session;
            idx_nxt     = LEN_W'(1);
            if (q_head.ent.length == LEN_W'(1)) begin
              s1_final_nxt       = 1'b1;
              back_stat.pop_done = 1'b1;
            end else begin
              state_nxt = B_STREAM;
            end
          end else begin
            s1_status_nxt = q_head.status;
            s1_final_nxt  = 1'b1;
          end
        end
      end
      B_STREAM: begin
        s1_valid_nxt = 1'b1;
        s1_kind_nxt  = KIND_BYTE;
        idx_nxt      = idx_r + 1'b1;
        if (idx_nxt == cur_len_r) begin
          s1_final_nxt       = 1'b1;
          back_stat.pop_done = 1'b1;
          state_nxt          = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= s1_valid_r;
    end
    idx_r        <= idx_nxt;
    cur_off_r    <= cur_off_nxt;
    cur_len_r    <= cur_len_nxt;
    cur_ses_r    <= cur_ses_nxt;
    s1_kind_r    <= s1_kind_nxt;
    s1_status_r  <= s1_status_nxt;
    s1_ses_r     <= s1_ses_nxt;
    s1_len_r     <= s1_len_nxt;
    s1_final_r   <= s1_final_nxt;
    out_kind_r   <= s1_kind_r;
    out_status_r <= s1_status_r;
    out_byte_r   <= (s1_kind_r == KIND_BYTE) ? rd_data : 8'd0;
    out_ses_r    <= s1_ses_r;
    out_len_r    <= s1_len_r;
    out_final_r  <= s1_final_r;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_status        = out_status_r;
  assign out_byte          = out_byte_r;
  assign out_session       = out_ses_r;
  assign out_packet_length = out_len_r;
  assign out_final_res     = out_final_r;

endmodule

// File: hw/rtl/variable_length_packet_stack.sv
// Top level of the variable-length packet stack: front end, job queue, back end, byte store.
//
// Channel   Ports                                      Handshake
// request   in_cmd in_data_byte in_last_byte           taken when start && !busy
//           in_session_tag
// result    out_kind out_status out_byte out_session   marked by out_valid
//           out_packet_length out_final_res
//
// A push byte is stored when taken unless its packet failed; the closing byte queues a status job.
// A non-empty pop passes the front end's idle and read states (entry table read), then streams
// its bytes from the byte store read port; busy stays high until the last byte has been read.
// Results pass the back end's s1 and output registers; busy also rises when the queue is full.
// Synchronous reset empties the stack, the queue and any open packet; no clearing pass is needed.
// The receiver cannot stall: out_valid marks each result for exactly one cycle.
module variable_length_packet_stack import vlps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_cmd,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last_byte,
  input  logic [SES_W-1:0] in_session_tag,
  output logic             out_valid,
  output logic             out_kind,
  output logic [2:0]       out_status,
  output logic [7:0]       out_byte,
  output logic [SES_W-1:0] out_session,
  output logic [LEN_W-1:0] out_packet_length,
  output logic             out_final_res
);

  logic               enq;
  job_t               enq_job;
  logic               deq;
  job_t               q_head;
  logic               q_full;
  logic               q_empty;
  back_stat_t         back_stat;
  byte_wr_t           byte_wr;
  logic [BYTE_AW-1:0] rd_addr;
  logic [7:0]         rd_data;

  vlps_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .cmd         (in_cmd),
    .data_byte   (in_data_byte),
    .last_byte   (in_last_byte),
    .session_tag (in_session_tag),
    .busy        (busy),
    .enq         (enq),
    .enq_job     (enq_job),
    .q_full      (q_full),
    .back_stat   (back_stat),
    .byte_wr     (byte_wr)
  );

  vlps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .enq     (enq),
    .enq_job (enq_job),
    .deq     (deq),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  vlps_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_byte_ram (
    .clk   (clk),
    .we    (byte_wr.we),
    .waddr (byte_wr.addr),
    .wdata (byte_wr.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  vlps_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .deq               (deq),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .back_stat         (back_stat),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_status        (out_status),
    .out_byte          (out_byte),
    .out_session       (out_session),
    .out_packet_length (out_packet_length),
    .out_final_res     (out_final_res)
  );

endmodule

// File: hw/rtl/vlps_checker.sv
// Port-level checks on the packet stack's results, bound to the top level.
module vlps_checker import vlps_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_kind,
  input logic [2:0]       out_status,
  input logic [7:0]       out_byte,
  input logic [SES_W-1:0] out_session,
  input logic [LEN_W-1:0] out_packet_length,
  input logic             out_final_res
);

  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STATUS |-> out_final_res && out_byte == 8'd0)
    else $error("status result not final or carries a byte");

  a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_BYTE |->
      out_status == ST_OK && out_packet_length != '0 &&
      out_packet_length <= LEN_W'(MAX_PACKET))
    else $error("popped byte with bad status or length");

  a_stream_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_BYTE && !out_final_res |=>
      out_valid && out_kind == KIND_BYTE &&
      $stable(out_session) && $stable(out_packet_length))
    else $error("pop stream broken or packet fields changed mid-packet");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |->
      out_kind == KIND_STATUS && out_session == '0 && out_packet_length == '0)
    else $error("empty result with non-zero fields");

endmodule

bind variable_length_packet_stack vlps_checker u_vlps_checker (.*);
